// ===== src/bchol_pkg.sv =====
// ----------------------------------------------------------------------------
// bchol_pkg
// Shared types and codes of the batched Cholesky factor-and-solve block.
// ----------------------------------------------------------------------------
package bchol_pkg;

   localparam int DATA_W = 32;

   // item opcodes
   localparam logic [2:0] OP_LOAD_M = 3'd0;
   localparam logic [2:0] OP_FACTOR = 3'd1;
   localparam logic [2:0] OP_LOAD_B = 3'd2;
   localparam logic [2:0] OP_SOLVE  = 3'd3;
   localparam logic [2:0] OP_DET    = 3'd4;

   // result status codes
   localparam logic [1:0] STS_OK       = 2'd0;
   localparam logic [1:0] STS_PIVOT    = 2'd1;
   localparam logic [1:0] STS_NOFACTOR = 2'd2;
   localparam logic [1:0] STS_SAT      = 2'd3;

   // register indexes
   localparam logic CSR_MATRIX_SIZE = 1'b0;
   localparam logic CSR_LANE_COUNT  = 1'b1;

   typedef enum logic [1:0] {
      ALU_MUL,
      ALU_SUB,
      ALU_DIV,
      ALU_SQRT
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   typedef struct packed {
      logic done;
      logic sat;
   } alu_rsp_type;

endpackage

// ===== src/bchol_ram.sv =====
// ----------------------------------------------------------------------------
// bchol_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bchol_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

// ===== src/bchol_alu.sv =====
// ----------------------------------------------------------------------------
// bchol_alu
// Shared fixed-point unit: rounded multiply, saturating subtract, rounded
// divide (one quotient bit per cycle) and rounded square root (one root bit
// per cycle). One operation at a time; done pulses with the result.
// ----------------------------------------------------------------------------
module bchol_alu
   import bchol_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                     clock,
   input  logic                     reset,
   input  alu_req_type              req,
   input  logic signed [DATA_W-1:0] a,
   input  logic signed [DATA_W-1:0] b,
   output alu_rsp_type              rsp,
   output logic signed [DATA_W-1:0] result
);

   localparam int NW   = 33 + FRAC_BITS;          // dividend width
   localparam int SW   = 32 + FRAC_BITS;          // radicand width
   localparam int SWE  = SW + (SW % 2);
   localparam int RB   = SWE / 2;                 // root bits
   localparam int RW   = RB + 2;                  // root remainder width
   localparam int CNTW = $clog2(NW + 1);

   typedef enum logic [2:0] {
      A_IDLE,
      A_MUL,
      A_DIV,
      A_DIVEND,
      A_SQRT,
      A_SQEND
   } alu_state_type;

   alu_state_type     st_ff;
   logic              done_ff;
   logic              sat_ff;
   logic signed [31:0] res_ff;
   logic signed [63:0] prod_ff;
   logic [NW-1:0]     num_ff;
   logic [31:0]       den_ff;
   logic [31:0]       drem_ff;
   logic              neg_ff;
   logic [CNTW-1:0]   cnt_ff;
   logic [SWE-1:0]    sx_ff;
   logic [RB-1:0]     root_ff;
   logic [RW-1:0]     srem_ff;

   logic signed [63:0] mul_rnd;
   logic signed [63:0] sub_diff;
   logic [32:0]        a_mag;
   logic [32:0]        b_mag;
   logic [NW-1:0]      num_init;
   logic [32:0]        drem2;
   logic [RW+1:0]      srem2;
   logic [RW+1:0]      trial;
   logic signed [NW:0] quot_s;
   logic [RB:0]        root_rnd;
   logic [32:0]        clamp_mul;
   logic [32:0]        clamp_sub;
   logic [32:0]        clamp_div;

   function automatic logic [32:0] clamp64(input logic signed [63:0] v);
      if (v > 64'sh0000_0000_7FFF_FFFF) begin
         return {1'b1, 32'h7FFF_FFFF};
      end else if (v < -64'sh0000_0000_8000_0000) begin
         return {1'b1, 32'h8000_0000};
      end
      return {1'b0, v[31:0]};
   endfunction

   always_comb begin
      mul_rnd   = (prod_ff + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
      sub_diff  = 64'(a) - 64'(b);
      a_mag     = a[31] ? (33'd0 - {1'b1, a}) : {1'b0, a};
      b_mag     = b[31] ? (33'd0 - {1'b1, b}) : {1'b0, b};
      num_init  = (NW'(a_mag) << FRAC_BITS) + NW'(b_mag[32:1]);
      drem2     = {drem_ff, num_ff[NW-1]};
      srem2     = {srem_ff, sx_ff[SWE-1 -: 2]};
      trial     = (RW + 2)'({root_ff, 2'b01});
      quot_s    = neg_ff ? -$signed({1'b0, num_ff}) : $signed({1'b0, num_ff});
      root_rnd  = {1'b0, root_ff} + (RB + 1)'(srem_ff > RW'(root_ff));
      clamp_mul = clamp64(mul_rnd);
      clamp_sub = clamp64(sub_diff);
      clamp_div = clamp64(64'(quot_s));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= A_IDLE;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (st_ff)
            A_IDLE: begin
               if (req.start) begin
                  case (req.op)
                     ALU_MUL: begin
                        prod_ff <= 64'(a) * 64'(b);
                        st_ff   <= A_MUL;
                     end
                     ALU_SUB: begin
                        res_ff  <= clamp_sub[31:0];
                        sat_ff  <= clamp_sub[32];
                        done_ff <= 1'b1;
                     end
                     ALU_DIV: begin
                        if (b == '0) begin
                           // divide by zero saturates toward the dividend's sign
                           res_ff  <= a[31] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
                           sat_ff  <= 1'b1;
                           done_ff <= 1'b1;
                        end else begin
                           num_ff  <= num_init;
                           den_ff  <= b_mag[31:0];
                           drem_ff <= '0;
                           neg_ff  <= a[31] ^ b[31];
                           cnt_ff  <= CNTW'(NW);
                           st_ff   <= A_DIV;
                        end
                     end
                     ALU_SQRT: begin
                        sx_ff   <= SWE'({a, FRAC_BITS'(0)});
                        root_ff <= '0;
                        srem_ff <= '0;
                        cnt_ff  <= CNTW'(RB);
                        st_ff   <= A_SQRT;
                     end
                     default: ;
                  endcase
               end
            end
            A_MUL: begin
               res_ff  <= clamp_mul[31:0];
               sat_ff  <= clamp_mul[32];
               done_ff <= 1'b1;
               st_ff   <= A_IDLE;
            end
            A_DIV: begin
               if (drem2 >= {1'b0, den_ff}) begin
                  drem_ff <= 32'(drem2 - {1'b0, den_ff});
                  num_ff  <= {num_ff[NW-2:0], 1'b1};
               end else begin
                  drem_ff <= drem2[31:0];
                  num_ff  <= {num_ff[NW-2:0], 1'b0};
               end
               cnt_ff <= cnt_ff - CNTW'(1);
               if (cnt_ff == CNTW'(1)) begin
                  st_ff <= A_DIVEND;
               end
            end
            A_DIVEND: begin
               res_ff  <= clamp_div[31:0];
               sat_ff  <= clamp_div[32];
               done_ff <= 1'b1;
               st_ff   <= A_IDLE;
            end
            A_SQRT: begin
               if (srem2 >= trial) begin
                  srem_ff <= RW'(srem2 - trial);
                  root_ff <= {root_ff[RB-2:0], 1'b1};
               end else begin
                  srem_ff <= RW'(srem2);
                  root_ff <= {root_ff[RB-2:0], 1'b0};
               end
               sx_ff  <= sx_ff << 2;
               cnt_ff <= cnt_ff - CNTW'(1);
               if (cnt_ff == CNTW'(1)) begin
                  st_ff <= A_SQEND;
               end
            end
            A_SQEND: begin
               res_ff  <= 32'(root_rnd);
               sat_ff  <= 1'b0;
               done_ff <= 1'b1;
               st_ff   <= A_IDLE;
            end
            default: st_ff <= A_IDLE;
         endcase
      end
   end

   assign rsp.done = done_ff;
   assign rsp.sat  = sat_ff;
   assign result   = res_ff;

endmodule

// ===== src/batched_cholesky_solver.sv =====
// ----------------------------------------------------------------------------
// batched_cholesky_solver
// Holds up to LANES symmetric matrices (lower triangles) and right-hand
// sides; factors them in place into L, solves L*L^T x = b, or returns the
// squared product of the diagonal of L. Signed fixed point, saturating.
//
//   port group  dir  payload
//   req_*       in   tuser: opcode[2:0]; tdata: row, col, lane, value
//   rsp_*       out  tuser: status[1:0]; tdata: value, row, lane; tlast
//   csr_*       in   index 0 matrix_size, 1 lane_count
//
// Loads are written to the stores as they are accepted. Factor, solve and
// determinant run on one shared multiply/subtract/divide/sqrt unit.
// req_tready is low while an item is in work and until its last result is
// taken. Reset is synchronous; it clears the factor-valid flag and restores
// matrix_size 8 and lane_count 4; the stores keep their contents.
// ----------------------------------------------------------------------------
module batched_cholesky_solver
   import bchol_pkg::*;
#(
   parameter int MAX_SIZE  = 8,
   parameter int LANES     = 4,
   parameter int FRAC_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // row[2:0], col[5:3], lane[7:6], value[39:8]
   input  logic [2:0]  req_tuser,   // opcode[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // value[31:0], row[34:32], lane[36:35], zero fill
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [3:0]  csr_wdata
);

   localparam int TRI_DEPTH = (MAX_SIZE * (MAX_SIZE + 1) / 2) * LANES;
   localparam int VEC_DEPTH = MAX_SIZE * LANES;
   localparam int TAW = (TRI_DEPTH > 1) ? $clog2(TRI_DEPTH) : 1;
   localparam int VAW = (VEC_DEPTH > 1) ? $clog2(VEC_DEPTH) : 1;
   localparam int IW  = ($clog2(MAX_SIZE + 1) > 3) ? $clog2(MAX_SIZE + 1) : 3;
   localparam int LW  = ($clog2(LANES + 1) > 2) ? $clog2(LANES + 1) : 2;
   localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

   typedef enum logic [4:0] {
      ST_IDLE,
      ST_INIT_RD,
      ST_INIT_CAP,
      ST_TERM,
      ST_A_CAP,
      ST_B_CAP,
      ST_MUL_GO,
      ST_MUL_W,
      ST_SUB_GO,
      ST_SUB_W,
      ST_FIN_CAP,
      ST_FIN_GO,
      ST_FIN_W,
      ST_DET_RD,
      ST_DET_CAP,
      ST_NEXT,
      ST_OUT_RD,
      ST_OUT_CAP,
      ST_OUT_WAIT
   } state_type;

   typedef enum logic [2:0] {
      PH_DIAG,
      PH_OFF,
      PH_FWD,
      PH_BWD,
      PH_DET,
      PH_DETSQ,
      PH_OUT
   } phase_type;

   state_type          state_ff;
   phase_type          phase_ff;
   logic [IW-1:0]      i_ff;
   logic [IW-1:0]      j_ff;
   logic [IW-1:0]      k_ff;
   logic [IW-1:0]      kc_ff;
   logic [LW-1:0]      l_ff;
   logic signed [31:0] s_ff;
   logic signed [31:0] ea_ff;
   logic signed [31:0] eb_ff;
   logic               sat_ff;
   logic               fv_ff;
   logic [3:0]         ms_ff;
   logic [2:0]         lc_ff;
   logic               rsp_valid_ff;
   logic [31:0]        rsp_value_ff;
   logic [2:0]         rsp_row_ff;
   logic [1:0]         rsp_lane_ff;
   logic [1:0]         rsp_status_ff;
   logic               rsp_last_ff;

   logic [2:0]         in_op;
   logic [2:0]         in_row;
   logic [2:0]         in_col;
   logic [1:0]         in_lane;
   logic [31:0]        in_value;
   logic               accept;
   logic               in_pos_ok;
   logic [IW-1:0]      n_w;
   logic [LW-1:0]      nl_w;
   logic               lane_wrap;
   logic               down;
   logic               more;
   logic [IW-1:0]      kt;
   logic [IW-1:0]      tr;
   logic [IW-1:0]      tc;
   logic [IW-1:0]      xr;
   logic               sat_any;

   logic               tri_we;
   logic [TAW-1:0]     tri_waddr;
   logic [31:0]        tri_wdata;
   logic [TAW-1:0]     tri_raddr;
   logic [31:0]        tri_rd;
   logic               vec_we;
   logic [VAW-1:0]     vec_waddr;
   logic [VAW-1:0]     vec_raddr;
   logic [31:0]        vec_rd;
   logic               x_we;
   logic [VAW-1:0]     x_waddr;
   logic [VAW-1:0]     x_raddr;
   logic [31:0]        x_rd;

   alu_req_type        alu_req;
   alu_rsp_type        alu_rsp;
   logic signed [31:0] alu_a;
   logic signed [31:0] alu_b;
   logic signed [31:0] alu_res;

   function automatic logic [TAW-1:0] tri_addr(input logic [IW-1:0] r,
                                                input logic [IW-1:0] c,
                                                input logic [LW-1:0] l);
      int t;
      t = (((int'(r) * (int'(r) + 1)) >> 1) + int'(c)) * LANES + int'(l);
      return TAW'(t);
   endfunction

   function automatic logic [VAW-1:0] vec_addr(input logic [IW-1:0] r,
                                                input logic [LW-1:0] l);
      int t;
      t = int'(r) * LANES + int'(l);
      return VAW'(t);
   endfunction

   assign in_op    = req_tuser;
   assign in_row   = req_tdata[2:0];
   assign in_col   = req_tdata[5:3];
   assign in_lane  = req_tdata[7:6];
   assign in_value = req_tdata[39:8];

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign in_pos_ok  = (32'(in_row) < MAX_SIZE) && (32'(in_lane) < LANES);

   always_comb begin
      if (ms_ff == '0) begin
         n_w = IW'(1);
      end else if (32'(ms_ff) > MAX_SIZE) begin
         n_w = IW'(MAX_SIZE);
      end else begin
         n_w = IW'(ms_ff);
      end
      if (lc_ff == '0) begin
         nl_w = LW'(1);
      end else if (32'(lc_ff) > LANES) begin
         nl_w = LW'(LANES);
      end else begin
         nl_w = LW'(lc_ff);
      end
   end

   assign lane_wrap = (l_ff == nl_w - LW'(1));
   assign down      = (phase_ff != PH_BWD);
   assign more      = down ? (k_ff != '0) : (k_ff < n_w);
   assign kt        = down ? (k_ff - IW'(1)) : k_ff;
   assign sat_any   = sat_ff || (alu_rsp.done && alu_rsp.sat);

   // triangle read position per state; default is the diagonal (i, i)
   always_comb begin
      tr = i_ff;
      tc = i_ff;
      case (state_ff)
         ST_INIT_RD: begin
            if (phase_ff == PH_OFF) begin
               tr = j_ff;
            end
         end
         ST_TERM: begin
            if (more) begin
               if (down) begin
                  tc = kt;
               end else begin
                  tr = kt;
               end
            end
         end
         ST_A_CAP: begin
            tr = j_ff;
            tc = kc_ff;
         end
         default: ;
      endcase
   end

   assign xr        = (state_ff == ST_A_CAP) ? kc_ff : i_ff;
   assign tri_raddr = tri_addr(tr, tc, l_ff);
   assign x_raddr   = vec_addr(xr, l_ff);
   assign vec_raddr = vec_addr(i_ff, l_ff);

   always_comb begin
      if (state_ff == ST_IDLE) begin
         tri_we    = accept && (in_op == OP_LOAD_M) && in_pos_ok && (in_col <= in_row);
         tri_waddr = tri_addr(IW'(in_row), IW'(in_col), LW'(in_lane));
         tri_wdata = in_value;
      end else begin
         tri_we    = (state_ff == ST_FIN_W) && alu_rsp.done &&
                     ((phase_ff == PH_DIAG) || (phase_ff == PH_OFF));
         tri_waddr = tri_addr((phase_ff == PH_OFF) ? j_ff : i_ff, i_ff, l_ff);
         tri_wdata = alu_res;
      end
   end

   assign vec_we    = accept && (in_op == OP_LOAD_B) && in_pos_ok;
   assign vec_waddr = vec_addr(IW'(in_row), LW'(in_lane));
   assign x_we      = (state_ff == ST_FIN_W) && alu_rsp.done &&
                      ((phase_ff == PH_FWD) || (phase_ff == PH_BWD));
   assign x_waddr   = vec_addr(i_ff, l_ff);

   always_comb begin
      alu_req.start = 1'b0;
      alu_req.op    = ALU_MUL;
      alu_a         = ea_ff;
      alu_b         = eb_ff;
      case (state_ff)
         ST_MUL_GO: begin
            alu_req.start = 1'b1;
         end
         ST_SUB_GO: begin
            alu_req.start = 1'b1;
            alu_req.op    = ALU_SUB;
            alu_a         = s_ff;
            alu_b         = ea_ff;
         end
         ST_FIN_GO: begin
            alu_req.start = 1'b1;
            alu_req.op    = (phase_ff == PH_DIAG) ? ALU_SQRT : ALU_DIV;
            alu_a         = s_ff;
         end
         default: ;
      endcase
   end

   bchol_ram #(.WIDTH(32), .DEPTH(TRI_DEPTH)) u_tri (
      .clock (clock),
      .we    (tri_we),
      .waddr (tri_waddr),
      .wdata (tri_wdata),
      .raddr (tri_raddr),
      .rdata (tri_rd)
   );

   bchol_ram #(.WIDTH(32), .DEPTH(VEC_DEPTH)) u_vec (
      .clock (clock),
      .we    (vec_we),
      .waddr (vec_waddr),
      .wdata (in_value),
      .raddr (vec_raddr),
      .rdata (vec_rd)
   );

   bchol_ram #(.WIDTH(32), .DEPTH(VEC_DEPTH)) u_x (
      .clock (clock),
      .we    (x_we),
      .waddr (x_waddr),
      .wdata (alu_res),
      .raddr (x_raddr),
      .rdata (x_rd)
   );

   bchol_alu #(.FRAC_BITS(FRAC_BITS)) u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .a      (alu_a),
      .b      (alu_b),
      .rsp    (alu_rsp),
      .result (alu_res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_DIAG;
         fv_ff        <= 1'b0;
         sat_ff       <= 1'b0;
         ms_ff        <= 4'd8;
         lc_ff        <= 3'd4;
         rsp_valid_ff <= 1'b0;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (in_op)
                     OP_LOAD_M: begin
                        if (tri_we) begin
                           fv_ff <= 1'b0;
                        end
                     end
                     OP_FACTOR: begin
                        fv_ff    <= 1'b0;
                        sat_ff   <= 1'b0;
                        i_ff     <= '0;
                        l_ff     <= '0;
                        k_ff     <= '0;
                        phase_ff <= PH_DIAG;
                        state_ff <= ST_INIT_RD;
                     end
                     OP_SOLVE, OP_DET: begin
                        if (!fv_ff) begin
                           rsp_value_ff  <= '0;
                           rsp_row_ff    <= '0;
                           rsp_lane_ff   <= '0;
                           rsp_status_ff <= STS_NOFACTOR;
                           rsp_last_ff   <= 1'b1;
                           rsp_valid_ff  <= 1'b1;
                           state_ff      <= ST_OUT_WAIT;
                        end else begin
                           sat_ff <= 1'b0;
                           i_ff   <= '0;
                           l_ff   <= '0;
                           k_ff   <= '0;
                           if (in_op == OP_SOLVE) begin
                              phase_ff <= PH_FWD;
                              state_ff <= ST_INIT_RD;
                           end else begin
                              s_ff     <= ONE;
                              phase_ff <= PH_DET;
                              state_ff <= ST_DET_RD;
                           end
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_INIT_RD: state_ff <= ST_INIT_CAP;
            ST_INIT_CAP: begin
               case (phase_ff)
                  PH_FWD:  s_ff <= vec_rd;
                  PH_BWD:  s_ff <= x_rd;
                  default: s_ff <= tri_rd;
               endcase
               state_ff <= ST_TERM;
            end
            ST_TERM: begin
               if (more) begin
                  kc_ff    <= kt;
                  k_ff     <= down ? kt : (k_ff + IW'(1));
                  state_ff <= ST_A_CAP;
               end else if (phase_ff == PH_DIAG) begin
                  if (s_ff <= 32'sd0) begin
                     // pivot failed: report its position, store stays as is
                     rsp_value_ff  <= '0;
                     rsp_row_ff    <= i_ff[2:0];
                     rsp_lane_ff   <= l_ff[1:0];
                     rsp_status_ff <= STS_PIVOT;
                     rsp_last_ff   <= 1'b1;
                     rsp_valid_ff  <= 1'b1;
                     state_ff      <= ST_OUT_WAIT;
                  end else begin
                     state_ff <= ST_FIN_GO;
                  end
               end else begin
                  state_ff <= ST_FIN_CAP;
               end
            end
            ST_A_CAP: begin
               ea_ff <= tri_rd;
               if (phase_ff == PH_DIAG) begin
                  eb_ff    <= tri_rd;
                  state_ff <= ST_MUL_GO;
               end else begin
                  state_ff <= ST_B_CAP;
               end
            end
            ST_B_CAP: begin
               eb_ff    <= (phase_ff == PH_OFF) ? tri_rd : x_rd;
               state_ff <= ST_MUL_GO;
            end
            ST_MUL_GO: state_ff <= ST_MUL_W;
            ST_MUL_W: begin
               if (alu_rsp.done) begin
                  sat_ff <= sat_any;
                  case (phase_ff)
                     PH_DET: begin
                        s_ff     <= alu_res;
                        state_ff <= ST_NEXT;
                     end
                     PH_DETSQ: begin
                        rsp_value_ff  <= alu_res;
                        rsp_row_ff    <= '0;
                        rsp_lane_ff   <= '0;
                        rsp_status_ff <= sat_any ? STS_SAT : STS_OK;
                        rsp_last_ff   <= 1'b1;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= ST_OUT_WAIT;
                     end
                     default: begin
                        ea_ff    <= alu_res;
                        state_ff <= ST_SUB_GO;
                     end
                  endcase
               end
            end
            ST_SUB_GO: state_ff <= ST_SUB_W;
            ST_SUB_W: begin
               if (alu_rsp.done) begin
                  sat_ff   <= sat_any;
                  s_ff     <= alu_res;
                  state_ff <= ST_TERM;
               end
            end
            ST_FIN_CAP: begin
               eb_ff    <= tri_rd;
               state_ff <= ST_FIN_GO;
            end
            ST_FIN_GO: state_ff <= ST_FIN_W;
            ST_FIN_W: begin
               if (alu_rsp.done) begin
                  sat_ff   <= sat_any;
                  state_ff <= ST_NEXT;
               end
            end
            ST_DET_RD: state_ff <= ST_DET_CAP;
            ST_DET_CAP: begin
               ea_ff    <= s_ff;
               eb_ff    <= tri_rd;
               state_ff <= ST_MUL_GO;
            end
            ST_NEXT: begin
               state_ff <= ST_INIT_RD;
               case (phase_ff)
                  PH_DIAG: begin
                     k_ff <= i_ff;
                     if (!lane_wrap) begin
                        l_ff <= l_ff + LW'(1);
                     end else if ((i_ff + IW'(1)) < n_w) begin
                        l_ff     <= '0;
                        j_ff     <= i_ff + IW'(1);
                        phase_ff <= PH_OFF;
                     end else begin
                        fv_ff         <= 1'b1;
                        rsp_value_ff  <= '0;
                        rsp_row_ff    <= '0;
                        rsp_lane_ff   <= '0;
                        rsp_status_ff <= sat_ff ? STS_SAT : STS_OK;
                        rsp_last_ff   <= 1'b1;
                        rsp_valid_ff  <= 1'b1;
                        state_ff      <= ST_OUT_WAIT;
                     end
                  end
                  PH_OFF: begin
                     k_ff <= i_ff;
                     if (!lane_wrap) begin
                        l_ff <= l_ff + LW'(1);
                     end else begin
                        l_ff <= '0;
                        if ((j_ff + IW'(1)) < n_w) begin
                           j_ff <= j_ff + IW'(1);
                        end else begin
                           i_ff     <= i_ff + IW'(1);
                           k_ff     <= i_ff + IW'(1);
                           phase_ff <= PH_DIAG;
                        end
                     end
                  end
                  PH_FWD: begin
                     if (!lane_wrap) begin
                        l_ff <= l_ff + LW'(1);
                        k_ff <= i_ff;
                     end else begin
                        l_ff <= '0;
                        if ((i_ff + IW'(1)) < n_w) begin
                           i_ff <= i_ff + IW'(1);
                           k_ff <= i_ff + IW'(1);
                        end else begin
                           // backward pass starts at the last row
                           i_ff     <= n_w - IW'(1);
                           k_ff     <= n_w;
                           phase_ff <= PH_BWD;
                        end
                     end
                  end
                  PH_BWD: begin
                     if (!lane_wrap) begin
                        l_ff <= l_ff + LW'(1);
                        k_ff <= i_ff + IW'(1);
                     end else begin
                        l_ff <= '0;
                        if (i_ff != '0) begin
                           i_ff <= i_ff - IW'(1);
                           k_ff <= i_ff;
                        end else begin
                           phase_ff <= PH_OUT;
                           state_ff <= ST_OUT_RD;
                        end
                     end
                  end
                  PH_DET: begin
                     state_ff <= ST_DET_RD;
                     if (!lane_wrap) begin
                        l_ff <= l_ff + LW'(1);
                     end else begin
                        l_ff <= '0;
                        if ((i_ff + IW'(1)) < n_w) begin
                           i_ff <= i_ff + IW'(1);
                        end else begin
                           ea_ff    <= s_ff;
                           eb_ff    <= s_ff;
                           phase_ff <= PH_DETSQ;
                           state_ff <= ST_MUL_GO;
                        end
                     end
                  end
                  default: state_ff <= ST_IDLE;
               endcase
            end
            ST_OUT_RD: state_ff <= ST_OUT_CAP;
            ST_OUT_CAP: begin
               rsp_value_ff  <= x_rd;
               rsp_row_ff    <= i_ff[2:0];
               rsp_lane_ff   <= l_ff[1:0];
               rsp_status_ff <= sat_ff ? STS_SAT : STS_OK;
               rsp_last_ff   <= (i_ff == n_w - IW'(1)) && lane_wrap;
               rsp_valid_ff  <= 1'b1;
               state_ff      <= ST_OUT_WAIT;
            end
            ST_OUT_WAIT: begin
               if (rsp_tready) begin
                  rsp_valid_ff <= 1'b0;
                  if (rsp_last_ff) begin
                     state_ff <= ST_IDLE;
                  end else begin
                     state_ff <= ST_OUT_RD;
                     if (!lane_wrap) begin
                        l_ff <= l_ff + LW'(1);
                     end else begin
                        l_ff <= '0;
                        i_ff <= i_ff + IW'(1);
                     end
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase

         // register writes win over the factor-valid update above
         if (csr_we) begin
            fv_ff <= 1'b0;
            if (csr_index == CSR_MATRIX_SIZE) begin
               ms_ff <= csr_wdata;
            end else if (csr_index == CSR_LANE_COUNT) begin
               lc_ff <= csr_wdata[2:0];
            end
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_lane_ff, rsp_row_ff, rsp_value_ff};
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_tready && rsp_tvalid))
      else $error("input taken while a result is pending");

   a_csr_clears_factor: assert property (@(posedge clock) disable iff (reset)
      csr_we |=> !fv_ff)
      else $error("register write left factor valid");

   a_x_write_phase: assert property (@(posedge clock) disable iff (reset)
      x_we |-> (phase_ff == PH_FWD || phase_ff == PH_BWD))
      else $error("work vector written outside substitution");

   a_alu_done_expected: assert property (@(posedge clock) disable iff (reset)
      alu_rsp.done |-> (state_ff == ST_MUL_W || state_ff == ST_SUB_W ||
                        state_ff == ST_FIN_W))
      else $error("arithmetic result arrived unexpectedly");

endmodule
